// ----- rtl/dsps_pkg.sv -----
// shared types, constants and sequence tables for the dual servo pwm sequencer
`default_nettype none
package dsps_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int POS_W      = 6;
  localparam int TICK_W     = 8;
  localparam int FRAME_W    = 9;
  localparam int MINT_W     = 9;
  localparam int AINT_W     = 7;
  localparam int BTN_W      = 5;
  localparam int SEQ_IDX_W  = 3;
  // auto threshold products, up to 8 * 127
  localparam int PROD_W     = 10;

  localparam logic [TICK_W-1:0] FRAME_LENGTH_RST    = 8'd251;
  localparam logic [MINT_W-1:0] MANUAL_INTERVAL_RST = 9'd7;
  localparam logic [POS_W-1:0]  POS_MIN_RST         = 6'd16;
  localparam logic [POS_W-1:0]  POS_MAX_RST         = 6'd32;
  localparam logic [AINT_W-1:0] AUTO_INTERVAL_RST   = 7'd100;
  localparam logic [POS_W-1:0]  POS_RST             = 6'd20;

  // button bit positions
  localparam int BTN_MODE   = 0;
  localparam int BTN_X_UP   = 1;
  localparam int BTN_X_DOWN = 2;
  localparam int BTN_Y_UP   = 3;
  localparam int BTN_Y_DOWN = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LENGTH    = 3'd0,
    REG_MANUAL_INTERVAL = 3'd1,
    REG_POS_MIN         = 3'd2,
    REG_POS_MAX         = 3'd3,
    REG_AUTO_INTERVAL   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic                 hit;
    logic                 wrap;
    logic [SEQ_IDX_W-1:0] idx;
  } auto_step_t;

  function automatic logic [POS_W-1:0] seq_x(input logic [SEQ_IDX_W-1:0] i);
    logic [POS_W-1:0] v;
    case (i)
      3'd0:    v = 6'd26;
      3'd1:    v = 6'd30;
      3'd2:    v = 6'd20;
      3'd3:    v = 6'd25;
      3'd4:    v = 6'd32;
      default: v = 6'd20;
    endcase
    return v;
  endfunction

  function automatic logic [POS_W-1:0] seq_y(input logic [SEQ_IDX_W-1:0] i);
    logic [POS_W-1:0] v;
    case (i)
      3'd0:    v = 6'd17;
      3'd1:    v = 6'd20;
      3'd2:    v = 6'd22;
      3'd3:    v = 6'd21;
      3'd4:    v = 6'd19;
      default: v = 6'd20;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dsps_if.sv -----
// valid/ready channel interfaces for tick items and result items
`default_nettype none
interface dsps_tick_if;
  logic                        valid;
  logic                        ready;
  logic [dsps_pkg::BTN_W-1:0]  buttons_n;

  modport source (output valid, output buttons_n, input ready);
  modport sink   (input valid, input buttons_n, output ready);
endinterface

interface dsps_result_if;
  logic                        valid;
  logic                        ready;
  logic                        servo_x_level;
  logic                        servo_y_level;
  logic                        manual_mode;
  logic [dsps_pkg::POS_W-1:0]  pos_x_out;
  logic [dsps_pkg::POS_W-1:0]  pos_y_out;

  modport source (output valid, output servo_x_level, output servo_y_level,
                  output manual_mode, output pos_x_out, output pos_y_out, input ready);
  modport sink   (input valid, input servo_x_level, input servo_y_level,
                  input manual_mode, input pos_x_out, input pos_y_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/dsps_auto_seq.sv -----
// auto sequence step decode: which table entry a frame count selects
`default_nettype none
module dsps_auto_seq #(
  parameter int AUTO_STEPS = 5
) (
  input  wire logic [dsps_pkg::FRAME_W-1:0] frame_count,
  input  wire logic [dsps_pkg::AINT_W-1:0]  auto_interval,
  output dsps_pkg::auto_step_t              step
);
  import dsps_pkg::*;

  localparam logic [SEQ_IDX_W-1:0] LAST_IDX = SEQ_IDX_W'(AUTO_STEPS - 1);
  localparam logic [PROD_W-1:0]    STEPS_W  = PROD_W'(AUTO_STEPS);

  logic [PROD_W-1:0]    fc_ext;
  logic [PROD_W-1:0]    ai_ext;
  logic [PROD_W-1:0]    top_thresh;
  logic                 match;
  logic [SEQ_IDX_W-1:0] match_idx;

  assign fc_ext     = PROD_W'(frame_count);
  assign ai_ext     = PROD_W'(auto_interval);
  assign top_thresh = STEPS_W * ai_ext;

  // lowest matching multiple wins
  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    for (int k = 7; k >= 1; k--) begin
      if (k < AUTO_STEPS) begin
        if (fc_ext == PROD_W'(k) * ai_ext) begin
          match     = 1'b1;
          match_idx = SEQ_IDX_W'(k - 1);
        end
      end
    end
  end

  always_comb begin
    step.wrap = !match && (fc_ext >= top_thresh);
    step.hit  = match || step.wrap;
    step.idx  = match ? match_idx : LAST_IDX;
  end

endmodule
`default_nettype wire

// ----- rtl/dual_servo_pwm_sequencer_core.sv -----
// dual servo pwm sequencer top level: one tick item per cycle while results are taken, one result per tick
// a result is registered and valid in the cycle after its tick transfer
// throughput: one tick per cycle; ticks keep flowing while a result waits in the
//   output register and is taken in the same cycle
// reset: synchronous rst restores register defaults, positions 20, auto mode,
//   counters and pin levels zero, and empties the output register
`default_nettype none
module dual_servo_pwm_sequencer_core #(
  parameter int AUTO_STEPS = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  dsps_tick_if.sink                              tick,
  dsps_result_if.source                          result,
  input  wire logic                              cfg_write,
  input  wire logic [dsps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dsps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dsps_pkg::*;

  // configuration
  logic [TICK_W-1:0] frame_length;
  logic [MINT_W-1:0] manual_interval;
  logic [POS_W-1:0]  pos_min;
  logic [POS_W-1:0]  pos_max;
  logic [AINT_W-1:0] auto_interval;

  // state
  logic [TICK_W-1:0]  tick_count;
  logic [FRAME_W-1:0] frame_count;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic               manual_flag;
  logic               mode_latched;
  dir_t               x_dir;
  dir_t               y_dir;
  logic [1:0]         pin_levels;

  logic [TICK_W-1:0]  tick_count_next;
  logic [FRAME_W-1:0] frame_count_next;
  logic [POS_W-1:0]   pos_x_next;
  logic [POS_W-1:0]   pos_y_next;
  logic               manual_flag_next;
  logic               mode_latched_next;
  dir_t               x_dir_next;
  dir_t               y_dir_next;
  logic [1:0]         pin_levels_next;

  logic [TICK_W:0]    t;
  logic               frame_end;
  logic [FRAME_W-1:0] fc_inc;
  auto_step_t         astep;
  logic               accept;
  logic               res_valid;
  logic [BTN_W-1:0]   btn;

  assign accept      = tick.valid && tick.ready;
  assign tick.ready  = !res_valid || result.ready;
  assign result.valid = res_valid;
  assign btn         = tick.buttons_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length    <= FRAME_LENGTH_RST;
      manual_interval <= MANUAL_INTERVAL_RST;
      pos_min         <= POS_MIN_RST;
      pos_max         <= POS_MAX_RST;
      auto_interval   <= AUTO_INTERVAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_LENGTH:    frame_length    <= cfg_data[TICK_W-1:0];
        REG_MANUAL_INTERVAL: manual_interval <= cfg_data[MINT_W-1:0];
        REG_POS_MIN:         pos_min         <= cfg_data[POS_W-1:0];
        REG_POS_MAX:         pos_max         <= cfg_data[POS_W-1:0];
        REG_AUTO_INTERVAL:   auto_interval   <= cfg_data[AINT_W-1:0];
        default: ;
      endcase
    end
  end

  assign t         = {1'b0, tick_count} + 9'd1;
  assign frame_end = t >= {1'b0, frame_length};
  assign fc_inc    = frame_end ? frame_count + 9'd1 : frame_count;

  dsps_auto_seq #(.AUTO_STEPS(AUTO_STEPS)) u_auto (
    .frame_count   (fc_inc),
    .auto_interval (auto_interval),
    .step          (astep)
  );

  always_comb begin
    pin_levels_next = pin_levels;
    if (t == {3'b000, pos_y}) pin_levels_next[0] = !pin_levels_next[0];
    if (t == {3'b000, pos_x}) pin_levels_next[1] = !pin_levels_next[1];
    tick_count_next = t[TICK_W-1:0];
    if (frame_end) begin
      pin_levels_next = 2'b11;
      tick_count_next = '0;
    end

    frame_count_next = fc_inc;
    pos_x_next       = pos_x;
    pos_y_next       = pos_y;
    x_dir_next       = x_dir;
    y_dir_next       = y_dir;
    if (frame_end) begin
      if (!manual_flag) begin
        if (astep.hit) begin
          pos_x_next = seq_x(astep.idx);
          pos_y_next = seq_y(astep.idx);
        end
        if (astep.wrap) frame_count_next = '0;
      end else if (fc_inc >= manual_interval) begin
        if (x_dir == DIR_UP)   pos_x_next = pos_x + 6'd1;
        if (x_dir == DIR_DOWN) pos_x_next = pos_x - 6'd1;
        if (y_dir == DIR_UP)   pos_y_next = pos_y + 6'd1;
        if (y_dir == DIR_DOWN) pos_y_next = pos_y - 6'd1;
        x_dir_next       = DIR_NONE;
        y_dir_next       = DIR_NONE;
        frame_count_next = '0;
      end
    end

    // mode button toggles once per press
    manual_flag_next  = manual_flag ^ (!btn[BTN_MODE] && !mode_latched);
    mode_latched_next = !btn[BTN_MODE];

    // down request wins over up
    if (!btn[BTN_X_UP]   && pos_x_next < pos_max) x_dir_next = DIR_UP;
    if (!btn[BTN_X_DOWN] && pos_x_next > pos_min) x_dir_next = DIR_DOWN;
    if (!btn[BTN_Y_UP]   && pos_y_next < pos_max) y_dir_next = DIR_UP;
    if (!btn[BTN_Y_DOWN] && pos_y_next > pos_min) y_dir_next = DIR_DOWN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      frame_count  <= '0;
      pos_x        <= POS_RST;
      pos_y        <= POS_RST;
      manual_flag  <= 1'b0;
      mode_latched <= 1'b0;
      x_dir        <= DIR_NONE;
      y_dir        <= DIR_NONE;
      pin_levels   <= '0;
    end else if (accept) begin
      tick_count   <= tick_count_next;
      frame_count  <= frame_count_next;
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      manual_flag  <= manual_flag_next;
      mode_latched <= mode_latched_next;
      x_dir        <= x_dir_next;
      y_dir        <= y_dir_next;
      pin_levels   <= pin_levels_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.servo_x_level <= pin_levels_next[1];
      result.servo_y_level <= pin_levels_next[0];
      result.manual_mode   <= manual_flag_next;
      result.pos_x_out     <= pos_x_next;
      result.pos_y_out     <= pos_y_next;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("tick transfer without a result");

  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_count != 8'hFF)
    else $error("tick counter out of range");

  a_frame_end_high: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> result.servo_x_level && result.servo_y_level)
    else $error("pulse outputs not set at frame end");

  a_mode_latch: assert property (@(posedge clk) disable iff (rst)
    accept |=> mode_latched == !$past(btn[BTN_MODE]))
    else $error("mode latch does not track mode button");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept && !$past(rst) |=> $stable(pos_x) && $stable(pos_y) && $stable(manual_flag))
    else $error("state moved without a tick transfer");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// testbench for the dual servo pwm sequencer core: tick stimulus, model prediction, result checks
`timescale 1ns / 100ps

module tb;
  import dsps_pkg::*;

  localparam int SEQ_STEPS      = 5;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_SHOWN      = 40;

  localparam logic [POS_W-1:0] X_SEQ [8] = '{6'd26, 6'd30, 6'd20, 6'd25, 6'd32, 6'd20, 6'd20, 6'd20};
  localparam logic [POS_W-1:0] Y_SEQ [8] = '{6'd17, 6'd20, 6'd22, 6'd21, 6'd19, 6'd20, 6'd20, 6'd20};

  typedef struct packed {
    logic             x_level;
    logic             y_level;
    logic             manual;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } servo_sample_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dsps_tick_if   tick_ch ();
  dsps_result_if res_ch ();

  dual_servo_pwm_sequencer_core #(
    .AUTO_STEPS(SEQ_STEPS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies
  logic [TICK_W-1:0]  cfg_frame_len;
  logic [MINT_W-1:0]  cfg_nudge_every;
  logic [POS_W-1:0]   cfg_pos_lo;
  logic [POS_W-1:0]   cfg_pos_hi;
  logic [AINT_W-1:0]  cfg_step_every;

  // servo state copies
  logic [TICK_W-1:0]  tick_cnt;
  logic [FRAME_W-1:0] frame_cnt;
  logic [POS_W-1:0]   x_pos;
  logic [POS_W-1:0]   y_pos;
  logic               manual_on;
  logic               mode_held;
  dir_t               x_req;
  dir_t               y_req;
  logic               x_pin;
  logic               y_pin;

  servo_sample_t pending_samples[$];

  int error_count;
  int ticks_sent;
  int results_checked;
  int configs_loaded;
  int frame_ends;
  int table_loads;
  int nudges;
  int mode_flips;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int mode_press_left;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void reset_model();
    cfg_frame_len   = FRAME_LENGTH_RST;
    cfg_nudge_every = MANUAL_INTERVAL_RST;
    cfg_pos_lo      = POS_MIN_RST;
    cfg_pos_hi      = POS_MAX_RST;
    cfg_step_every  = AUTO_INTERVAL_RST;
    tick_cnt  = '0;
    frame_cnt = '0;
    x_pos     = POS_RST;
    y_pos     = POS_RST;
    manual_on = 1'b0;
    mode_held = 1'b0;
    x_req     = DIR_NONE;
    y_req     = DIR_NONE;
    x_pin     = 1'b0;
    y_pin     = 1'b0;
  endfunction

  function automatic void step_sequence();
    bit hit;
    hit = 1'b0;
    for (int k = 1; k < SEQ_STEPS; k++) begin
      if (!hit && int'(frame_cnt) == k * int'(cfg_step_every)) begin
        x_pos = X_SEQ[(k - 1) & 7];
        y_pos = Y_SEQ[(k - 1) & 7];
        hit = 1'b1;
        table_loads++;
      end
    end
    if (!hit && int'(frame_cnt) >= SEQ_STEPS * int'(cfg_step_every)) begin
      x_pos = X_SEQ[(SEQ_STEPS - 1) & 7];
      y_pos = Y_SEQ[(SEQ_STEPS - 1) & 7];
      frame_cnt = '0;
      table_loads++;
    end
  endfunction

  function automatic void apply_nudge();
    if (int'(frame_cnt) >= int'(cfg_nudge_every)) begin
      if (x_req == DIR_UP)   x_pos = x_pos + 6'd1;
      if (x_req == DIR_DOWN) x_pos = x_pos - 6'd1;
      if (y_req == DIR_UP)   y_pos = y_pos + 6'd1;
      if (y_req == DIR_DOWN) y_pos = y_pos - 6'd1;
      x_req = DIR_NONE;
      y_req = DIR_NONE;
      frame_cnt = '0;
      nudges++;
    end
  endfunction

  function automatic servo_sample_t advance_tick(input logic [BTN_W-1:0] btn);
    int t;
    servo_sample_t s;
    t = int'(tick_cnt) + 1;
    if (t == int'(y_pos)) y_pin = ~y_pin;
    if (t == int'(x_pos)) x_pin = ~x_pin;
    if (t >= int'(cfg_frame_len)) begin
      x_pin = 1'b1;
      y_pin = 1'b1;
      t = 0;
      frame_cnt = frame_cnt + 9'd1;
      frame_ends++;
      if (!manual_on) step_sequence();
      else apply_nudge();
    end
    tick_cnt = TICK_W'(t);

    if (!btn[BTN_MODE] && !mode_held) begin
      manual_on = ~manual_on;
      mode_held = 1'b1;
      mode_flips++;
    end
    if (btn[BTN_MODE] && mode_held) mode_held = 1'b0;

    if (!btn[BTN_X_UP]   && x_pos < cfg_pos_hi) x_req = DIR_UP;
    if (!btn[BTN_X_DOWN] && x_pos > cfg_pos_lo) x_req = DIR_DOWN;
    if (!btn[BTN_Y_UP]   && y_pos < cfg_pos_hi) y_req = DIR_UP;
    if (!btn[BTN_Y_DOWN] && y_pos > cfg_pos_lo) y_req = DIR_DOWN;

    s.x_level = x_pin;
    s.y_level = y_pin;
    s.manual  = manual_on;
    s.pos_x   = x_pos;
    s.pos_y   = y_pos;
    return s;
  endfunction

  // mode presses come as short held runs, direction buttons per tick, a little raw noise
  function automatic logic [BTN_W-1:0] next_buttons(input int mode_pct, input int dir_pct);
    logic [BTN_W-1:0] b;
    b = '1;
    if ($urandom_range(99) < 4) return BTN_W'($urandom);
    if (mode_press_left == 0 && $urandom_range(99) < mode_pct)
      mode_press_left = $urandom_range(1, 5);
    if (mode_press_left > 0) begin
      b[BTN_MODE] = 1'b0;
      mode_press_left--;
    end
    if ($urandom_range(99) < dir_pct) b[BTN_X_UP]   = 1'b0;
    if ($urandom_range(99) < dir_pct) b[BTN_X_DOWN] = 1'b0;
    if ($urandom_range(99) < dir_pct) b[BTN_Y_UP]   = 1'b0;
    if ($urandom_range(99) < dir_pct) b[BTN_Y_DOWN] = 1'b0;
    return b;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_SHOWN)
      $display("ERROR result %0d: %s is %0d, expected %0d", results_checked, what, got, want);
  endtask

  task automatic send_tick(input logic [BTN_W-1:0] btn);
    while ($urandom_range(99) < tx_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid     <= 1'b1;
    tick_ch.buttons_n <= btn;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    pending_samples.push_back(advance_tick(btn));
    ticks_sent++;
  endtask

  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input cfg_reg_t r, input int value);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    case (r)
      REG_FRAME_LENGTH:    cfg_frame_len   = TICK_W'(value);
      REG_MANUAL_INTERVAL: cfg_nudge_every = MINT_W'(value);
      REG_POS_MIN:         cfg_pos_lo      = POS_W'(value);
      REG_POS_MAX:         cfg_pos_hi      = POS_W'(value);
      REG_AUTO_INTERVAL:   cfg_step_every  = AINT_W'(value);
      default: ;
    endcase
  endtask

  task automatic load_config(input int flen, input int mint, input int pmin, input int pmax,
                             input int aint);
    drain_results();
    set_register(REG_FRAME_LENGTH, flen);
    set_register(REG_MANUAL_INTERVAL, mint);
    set_register(REG_POS_MIN, pmin);
    set_register(REG_POS_MAX, pmax);
    set_register(REG_AUTO_INTERVAL, aint);
    cfg_write <= 1'b0;
    configs_loaded++;
  endtask

  task automatic random_config();
    bit wide;
    wide = ($urandom_range(3) == 0);
    load_config(wide ? $urandom_range(2, 255) : $urandom_range(2, 12),
                wide ? $urandom_range(1, 511) : $urandom_range(1, 6),
                wide ? $urandom_range(0, 63)  : $urandom_range(10, 24),
                wide ? $urandom_range(0, 63)  : $urandom_range(18, 40),
                wide ? $urandom_range(1, 102) : $urandom_range(1, 5));
  endtask

  task automatic test_directed();
    logic [BTN_W-1:0] pattern [20];
    pattern = '{5'b11111, 5'b00000, 5'b00000, 5'b11111, 5'b11101,
                5'b11011, 5'b10111, 5'b01111, 5'b11001, 5'b00111,
                5'b11111, 5'b11110, 5'b11111, 5'b11111, 5'b11110,
                5'b11110, 5'b11111, 5'b10101, 5'b01011, 5'b11111};
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // shortest frame, nudge and table step every frame, widest bounds
    load_config(2, 1, 0, 63, 1);
    foreach (pattern[i]) send_tick(pattern[i]);
    // equal bounds accept a nudge request only when it moves a position toward the bound value
    load_config(2, 1, 20, 20, 1);
    send_tick(5'b00000);
    send_tick(5'b11111);
    send_tick(5'b10101);
    send_tick(5'b01011);
  endtask

  task automatic test_auto_sequence();
    tx_idle_pct = 22;
    rx_idle_pct = 55;
    load_config($urandom_range(2, 8), $urandom_range(1, 4), 16, 32, $urandom_range(1, 5));
    repeat (350) send_tick(next_buttons(1, 15));
  endtask

  task automatic test_manual_nudges();
    tx_idle_pct = 55;
    rx_idle_pct = 22;
    load_config($urandom_range(2, 8), $urandom_range(1, 6), $urandom_range(12, 20),
                $urandom_range(20, 30), $urandom_range(1, 5));
    repeat (350) send_tick(next_buttons(2, 35));
  endtask

  task automatic test_mixed_random();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (4) begin
      random_config();
      repeat (130) send_tick(next_buttons(2, 25));
    end
  endtask

  task automatic test_extreme_config();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_config(255, 511, 63, 0, 102);
    repeat (200) send_tick(next_buttons(2, 40));
    load_config(2, 1, 0, 63, 102);
    repeat (150) send_tick(next_buttons(2, 40));
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    drain_results();
    hold_req++;
    repeat (60) send_tick(next_buttons(3, 30));
  endtask

  initial begin : rx_driver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    servo_sample_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected result count", 1, 0);
      end else begin
        want = pending_samples.pop_front();
        results_checked++;
        if (res_ch.servo_x_level !== want.x_level)
          report_mismatch("servo_x_level", int'(res_ch.servo_x_level), int'(want.x_level));
        if (res_ch.servo_y_level !== want.y_level)
          report_mismatch("servo_y_level", int'(res_ch.servo_y_level), int'(want.y_level));
        if (res_ch.manual_mode !== want.manual)
          report_mismatch("manual_mode", int'(res_ch.manual_mode), int'(want.manual));
        if (res_ch.pos_x_out !== want.pos_x)
          report_mismatch("pos_x_out", int'(res_ch.pos_x_out), int'(want.pos_x));
        if (res_ch.pos_y_out !== want.pos_y)
          report_mismatch("pos_y_out", int'(res_ch.pos_y_out), int'(want.pos_y));
      end
    end
  end

  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    error_count     = 0;
    ticks_sent      = 0;
    results_checked = 0;
    configs_loaded  = 0;
    frame_ends      = 0;
    table_loads     = 0;
    nudges          = 0;
    mode_flips      = 0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    hold_req        = 0;
    mode_press_left = 0;
    rst               <= 1'b1;
    cfg_write         <= 1'b0;
    cfg_index         <= REG_FRAME_LENGTH;
    cfg_data          <= '0;
    tick_ch.valid     <= 1'b0;
    tick_ch.buttons_n <= '1;
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_auto_sequence();
    test_manual_nudges();
    test_mixed_random();
    test_extreme_config();
    test_backpressure();

    drain_results();
    $display("%0d ticks sent, %0d results checked, %0d register settings", ticks_sent,
             results_checked, configs_loaded);
    $display("%0d frame ends, %0d table steps, %0d manual nudges, %0d mode toggles",
             frame_ends, table_loads, nudges, mode_flips);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- dual_servo_pwm_sequencer_core.f -----
rtl/dsps_pkg.sv
rtl/dsps_if.sv
rtl/dsps_auto_seq.sv
rtl/dual_servo_pwm_sequencer_core.sv
dv/tb.sv
